// ----- design/fbd_pkg.sv -----
// Shared constants and control types for the page framebuffer drawing block.
`default_nettype none
package fbd_pkg;

  localparam int unsigned SCREEN_WIDTH  = 128;
  localparam int unsigned SCREEN_HEIGHT = 64;
  localparam int unsigned PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int unsigned STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;

  localparam int unsigned X_LAST = SCREEN_WIDTH - 1;
  localparam int unsigned Y_LAST = SCREEN_HEIGHT - 1;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned PG_W   = 3;
  localparam int unsigned COL_W  = $clog2(SCREEN_WIDTH);
  localparam int unsigned PAGE_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int unsigned YP_W   = PAGE_W + 3;
  localparam int unsigned ADDR_W = $clog2(STORE_BYTES);

  localparam logic [CMD_W-1:0] CMD_PIXEL  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FILL   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_BORDER = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  typedef struct packed {
    logic load_cmd;
    logic load_init;
    logic issue;
  } ctl_t;

  typedef struct packed {
    logic walk_last;
    logic hold_full;
  } sts_t;

endpackage
`default_nettype wire

// ----- design/fbd_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module fbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- design/fbd_ctrl.sv -----
// Controller state machine: start-up clear, command acceptance and byte walk sequencing.
`default_nettype none
module fbd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire fbd_pkg::sts_t sts_i,
  output fbd_pkg::ctl_t      ctl_o
);
  import fbd_pkg::*;

  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  logic [1:0] state_q, state_d;
  logic       take;
  logic       issue;

  assign in_stall_o = !((state_q == ST_IDLE) && !sts_i.hold_full);
  assign take       = in_valid_i && !in_stall_o;
  assign issue      = (state_q == ST_WALK) && !sts_i.hold_full;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        state_d = ST_WALK;
      end
      ST_IDLE: begin
        if (take) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (issue && sts_i.walk_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign ctl_o.load_cmd  = take;
  assign ctl_o.load_init = (state_q == ST_INIT);
  assign ctl_o.issue     = issue;

endmodule
`default_nettype wire

// ----- design/fbd_datapath.sv -----
// Datapath: command setup, byte walker, read-modify-write stage, frame store and result buffer.
`default_nettype none
module fbd_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fbd_pkg::ctl_t                 ctl_i,
  output fbd_pkg::sts_t                      sts_o,
  input  wire logic [fbd_pkg::CMD_W-1:0]     cmd_i,
  input  wire logic [fbd_pkg::POS_W-1:0]     pos_x_i,
  input  wire logic [fbd_pkg::POS_W-1:0]     pos_y_i,
  input  wire logic [fbd_pkg::POS_W-1:0]     rect_width_i,
  input  wire logic [fbd_pkg::POS_W-1:0]     rect_height_i,
  input  wire logic                          color_i,
  input  wire logic                          style_i,
  input  wire logic [fbd_pkg::PG_W-1:0]      page_i,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic      [fbd_pkg::BYTE_W-1:0]    read_data_o
);
  import fbd_pkg::*;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SET,
    OP_RESET,
    OP_BORDER,
    OP_ZERO,
    OP_READ
  } op_e;

  // Command setup.
  logic              x_ok, y_ok, pg_ok;
  logic [POS_W:0]    x_sum, y_sum, x_end, y_end, x_last, y_last;
  logic [COL_W-1:0]  set_col_lo, set_col_hi;
  logic [PAGE_W-1:0] set_page_lo, set_page_hi;
  logic [YP_W-1:0]   set_ylo, set_yhi;
  op_e               set_op;

  assign x_ok   = {1'b0, pos_x_i} < (POS_W + 1)'(SCREEN_WIDTH);
  assign y_ok   = {1'b0, pos_y_i} < (POS_W + 1)'(SCREEN_HEIGHT);
  assign pg_ok  = {2'b00, page_i} < (PG_W + 2)'(PAGE_COUNT);
  assign x_sum  = {1'b0, pos_x_i} + {1'b0, rect_width_i};
  assign y_sum  = {1'b0, pos_y_i} + {1'b0, rect_height_i};
  assign x_end  = (x_sum < (POS_W + 1)'(SCREEN_WIDTH)) ? x_sum : (POS_W + 1)'(SCREEN_WIDTH);
  assign y_end  = (y_sum < (POS_W + 1)'(SCREEN_HEIGHT)) ? y_sum : (POS_W + 1)'(SCREEN_HEIGHT);
  assign x_last = x_end - (POS_W + 1)'(1);
  assign y_last = y_end - (POS_W + 1)'(1);

  always_comb begin
    set_col_lo  = '0;
    set_col_hi  = '0;
    set_page_lo = '0;
    set_page_hi = '0;
    set_ylo     = '0;
    set_yhi     = '0;
    set_op      = OP_NONE;
    unique case (cmd_i)
      CMD_PIXEL: begin
        if (x_ok && y_ok) begin
          set_col_lo  = pos_x_i[COL_W-1:0];
          set_col_hi  = pos_x_i[COL_W-1:0];
          set_page_lo = pos_y_i[PAGE_W+2:3];
          set_page_hi = pos_y_i[PAGE_W+2:3];
          set_ylo     = pos_y_i[YP_W-1:0];
          set_yhi     = pos_y_i[YP_W-1:0];
          set_op      = color_i ? OP_SET : OP_RESET;
        end
      end
      CMD_FILL: begin
        if (x_ok && y_ok && (rect_width_i != '0) && (rect_height_i != '0)) begin
          set_col_lo  = pos_x_i[COL_W-1:0];
          set_col_hi  = x_last[COL_W-1:0];
          set_page_lo = pos_y_i[PAGE_W+2:3];
          set_page_hi = y_last[PAGE_W+2:3];
          set_ylo     = pos_y_i[YP_W-1:0];
          set_yhi     = y_last[YP_W-1:0];
          set_op      = OP_SET;
        end
      end
      CMD_BORDER: begin
        set_col_hi  = COL_W'(X_LAST);
        set_page_hi = PAGE_W'(PAGE_COUNT - 1);
        set_op      = OP_BORDER;
      end
      CMD_CLEAR: begin
        set_col_hi  = COL_W'(X_LAST);
        set_page_hi = PAGE_W'(PAGE_COUNT - 1);
        set_op      = OP_ZERO;
      end
      CMD_READ: begin
        if (x_ok && pg_ok) begin
          set_col_lo  = pos_x_i[COL_W-1:0];
          set_col_hi  = pos_x_i[COL_W-1:0];
          set_page_lo = PAGE_W'(page_i);
          set_page_hi = PAGE_W'(page_i);
          set_op      = OP_READ;
        end
      end
      default: begin
        set_op = OP_NONE;
      end
    endcase
  end

  // Byte walker over a column range within a page range.
  logic [COL_W-1:0]  col_q, col_lo_q, col_hi_q;
  logic [PAGE_W-1:0] page_q, page_hi_q;
  logic [YP_W-1:0]   ylo_q, yhi_q;
  op_e               op_q;
  logic              style_q;
  logic              reply_q;
  logic              walk_last;

  assign walk_last = (col_q == col_hi_q) && (page_q == page_hi_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_init) begin
      col_q     <= '0;
      col_lo_q  <= '0;
      col_hi_q  <= COL_W'(X_LAST);
      page_q    <= '0;
      page_hi_q <= PAGE_W'(PAGE_COUNT - 1);
      ylo_q     <= '0;
      yhi_q     <= '0;
      op_q      <= OP_ZERO;
      style_q   <= 1'b0;
    end else if (ctl_i.load_cmd) begin
      col_q     <= set_col_lo;
      col_lo_q  <= set_col_lo;
      col_hi_q  <= set_col_hi;
      page_q    <= set_page_lo;
      page_hi_q <= set_page_hi;
      ylo_q     <= set_ylo;
      yhi_q     <= set_yhi;
      op_q      <= set_op;
      style_q   <= style_i;
    end else if (ctl_i.issue && !walk_last) begin
      if (col_q == col_hi_q) begin
        col_q  <= col_lo_q;
        page_q <= page_q + PAGE_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reply_q <= 1'b0;
    end else if (ctl_i.load_init) begin
      reply_q <= 1'b0;
    end else if (ctl_i.load_cmd) begin
      reply_q <= 1'b1;
    end
  end

  // Per-bit masks of the byte under the walker.
  logic [BYTE_W-1:0] range_mask, border_mask;

  for (genvar b = 0; b < BYTE_W; b++) begin : g_bit
    logic [YP_W-1:0] yb;
    logic            on_screen, edge_row, edge_col;
    assign yb          = {page_q, 3'(b)};
    assign on_screen   = {1'b0, yb} < (YP_W + 1)'(SCREEN_HEIGHT);
    assign edge_row    = (yb == '0) || (yb == YP_W'(Y_LAST));
    assign edge_col    = (col_q == '0) || (col_q == COL_W'(X_LAST));
    assign range_mask[b]  = (yb >= ylo_q) && (yb <= yhi_q);
    assign border_mask[b] = on_screen &&
                            ((edge_row && (style_q || !col_q[0])) ||
                             (edge_col && (style_q || !yb[0])));
  end

  logic [ADDR_W-1:0] issue_addr;
  assign issue_addr = ADDR_W'(page_q) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col_q);

  // Read-modify-write stage.
  logic              stg_valid_q, stg_last_q, stg_reply_q;
  logic [ADDR_W-1:0] stg_addr_q;
  logic [BYTE_W-1:0] stg_mask_q;
  op_e               stg_op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
      stg_last_q  <= 1'b0;
      stg_reply_q <= 1'b0;
    end else begin
      stg_valid_q <= ctl_i.issue;
      stg_last_q  <= ctl_i.issue && walk_last;
      stg_reply_q <= reply_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.issue) begin
      stg_addr_q <= issue_addr;
      stg_mask_q <= (op_q == OP_BORDER) ? border_mask : range_mask;
      stg_op_q   <= op_q;
    end
  end

  logic              ram_we;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    unique case (stg_op_q)
      OP_SET, OP_BORDER: begin
        ram_we    = stg_valid_q;
        ram_wdata = ram_rdata | stg_mask_q;
      end
      OP_RESET: begin
        ram_we    = stg_valid_q;
        ram_wdata = ram_rdata & ~stg_mask_q;
      end
      OP_ZERO: begin
        ram_we    = stg_valid_q;
        ram_wdata = '0;
      end
      default: begin
        ram_we    = 1'b0;
        ram_wdata = '0;
      end
    endcase
  end

  fbd_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(STORE_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(stg_addr_q),
    .wdata_i(ram_wdata),
    .re_i   (ctl_i.issue),
    .raddr_i(issue_addr),
    .rdata_o(ram_rdata)
  );

  // Result output register with one holding slot behind it.
  logic              push, out_free;
  logic [BYTE_W-1:0] result;
  logic              out_valid_q, hold_valid_q;
  logic [BYTE_W-1:0] out_data_q, hold_data_q;

  assign push     = stg_valid_q && stg_last_q && stg_reply_q;
  assign result   = (stg_op_q == OP_READ) ? ram_rdata : '0;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      priority if (hold_valid_q) begin
        if (out_free) begin
          out_valid_q  <= 1'b1;
          hold_valid_q <= 1'b0;
        end
      end else if (push) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
        end else begin
          hold_valid_q <= 1'b1;
        end
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (hold_valid_q) begin
      if (out_free) begin
        out_data_q <= hold_data_q;
      end
    end else if (push) begin
      if (out_free) begin
        out_data_q <= result;
      end else begin
        hold_data_q <= result;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = out_data_q;
  assign sts_o.walk_last = walk_last;
  assign sts_o.hold_full = hold_valid_q;

  a_no_push_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hold_valid_q && push))
    else $error("result finished while the holding slot was full");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ctl_i.issue && (stg_addr_q == issue_addr)))
    else $error("read and write of the same byte in one cycle");

  a_read_single_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_valid_q && (stg_op_q == OP_READ)) |-> stg_last_q)
    else $error("read command walked more than one byte");

  a_walk_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.issue |-> ((col_q <= col_hi_q) && (page_q <= page_hi_q)))
    else $error("byte walker left its bounds");

endmodule
`default_nettype wire

// ----- design/mono_page_framebuffer_draw_core.sv -----
// Top level of the monochrome page framebuffer drawing block.
//
// The block holds a 128x64 one-bit image in page order: each byte is eight
// vertical pixels of one column, LSB on top. One command word enters on the
// input channel (in_valid_i / in_stall_o) and produces exactly one result
// word on the output channel (out_valid_o / out_stall_i); read_data_o holds
// the page byte for a read command and zero for every other command.
// Every command walks bytes of the frame store through a read-modify-write
// stage at one byte per cycle while the holding slot is free, so its cost
// is set by the store's single read and single write port. Pixel, read and
// dropped commands take one byte; the next command is taken once it issues,
// and out_valid_o rises once it has passed the read-modify-write stage and
// the output register. A rectangle walks columns times pages bytes; border
// and clear walk all 1024 bytes. After reset the store is swept to zero, one
// byte per cycle, and in_stall_o stays high until the sweep ends. A finished
// result waits in the output register while the receiver stalls, one more
// can wait behind it; both full, the walk stops and in_stall_o stays high.
`default_nettype none
module mono_page_framebuffer_draw_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [fbd_pkg::CMD_W-1:0]  cmd_i,
  input  wire logic [fbd_pkg::POS_W-1:0]  pos_x_i,
  input  wire logic [fbd_pkg::POS_W-1:0]  pos_y_i,
  input  wire logic [fbd_pkg::POS_W-1:0]  rect_width_i,
  input  wire logic [fbd_pkg::POS_W-1:0]  rect_height_i,
  input  wire logic                       color_i,
  input  wire logic                       style_i,
  input  wire logic [fbd_pkg::PG_W-1:0]   page_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic      [fbd_pkg::BYTE_W-1:0] read_data_o
);
  import fbd_pkg::*;

  ctl_t ctl;
  sts_t sts;

  fbd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .ctl_o     (ctl)
  );

  fbd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .cmd_i        (cmd_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .rect_width_i (rect_width_i),
    .rect_height_i(rect_height_i),
    .color_i      (color_i),
    .style_i      (style_i),
    .page_i       (page_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .read_data_o  (read_data_o)
  );

endmodule
`default_nettype wire

// ----- sim/mono_page_framebuffer_draw_core_tb.sv -----
// Self-checking testbench for the page framebuffer drawing block.
`timescale 1ns / 1ps
module mono_page_framebuffer_draw_core_tb;
  import fbd_pkg::*;

  localparam int unsigned CLK_HALF = 6;
  localparam longint unsigned TIMEOUT_NS = 64'd12 * 64'd8_000_000;
  localparam int unsigned RANDOM_WORDS = 1552;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam logic [CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LAST = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] rect_width;
    logic [POS_W-1:0] rect_height;
    logic             color;
    logic             style;
    logic [PG_W-1:0]  page;
  } draw_word_t;

  // Mirrors the frame store and holds the result bytes still owed by the block.
  class frame_mirror;
    logic [BYTE_W-1:0] image [STORE_BYTES];
    logic [BYTE_W-1:0] read_bytes_due [$];
    int unsigned fail_count;
    int unsigned result_index;

    function new();
      foreach (image[a]) image[a] = '0;
      fail_count = 0;
      result_index = 0;
    endfunction

    function void plot_pixel(int unsigned x, int unsigned y, logic lit);
      int unsigned addr;
      int unsigned bit_pos;
      if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) return;
      addr = (y / 8) * SCREEN_WIDTH + x;
      bit_pos = y % 8;
      image[addr][bit_pos] = lit;
    endfunction

    function logic [BYTE_W-1:0] apply_command(draw_word_t w);
      int unsigned stride;
      logic [BYTE_W-1:0] data;
      data = '0;
      case (w.cmd)
        CMD_PIXEL: plot_pixel(32'(w.pos_x), 32'(w.pos_y), w.color);
        CMD_FILL: begin
          for (int unsigned i = 0; i < w.rect_width && w.pos_x + i < SCREEN_WIDTH; i++)
            for (int unsigned j = 0; j < w.rect_height && w.pos_y + j < SCREEN_HEIGHT; j++)
              plot_pixel(w.pos_x + i, w.pos_y + j, 1'b1);
        end
        CMD_BORDER: begin
          stride = w.style ? 1 : 2;
          for (int unsigned i = 0; i < SCREEN_WIDTH; i += stride) begin
            plot_pixel(i, 0, 1'b1);
            plot_pixel(i, Y_LAST, 1'b1);
          end
          for (int unsigned i = 0; i < SCREEN_HEIGHT; i += stride) begin
            plot_pixel(0, i, 1'b1);
            plot_pixel(X_LAST, i, 1'b1);
          end
        end
        CMD_CLEAR: foreach (image[a]) image[a] = '0;
        CMD_READ: begin
          if (w.pos_x < SCREEN_WIDTH && w.page < PAGE_COUNT)
            data = image[w.page * SCREEN_WIDTH + w.pos_x];
        end
        default: ;
      endcase
      return data;
    endfunction

    function void note_word(draw_word_t w);
      read_bytes_due.push_back(apply_command(w));
    endfunction

    function void check_word(logic [BYTE_W-1:0] got);
      logic [BYTE_W-1:0] want;
      result_index++;
      if (read_bytes_due.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("ERROR: result %0d arrived with nothing expected, read_data=%h",
                   result_index, got);
        return;
      end
      want = read_bytes_due.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("ERROR: result %0d read_data expected %h got %h",
                   result_index, want, got);
      end
    endfunction

    function int unsigned pending_count();
      return read_bytes_due.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic drv_valid = 1'b0;
  draw_word_t drv_word = '0;
  logic rcv_stall = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic [BYTE_W-1:0] read_data_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_seq = 0;

  frame_mirror mirror = new();

  mono_page_framebuffer_draw_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (drv_valid),
    .in_stall_o    (in_stall_o),
    .cmd_i         (drv_word.cmd),
    .pos_x_i       (drv_word.pos_x),
    .pos_y_i       (drv_word.pos_y),
    .rect_width_i  (drv_word.rect_width),
    .rect_height_i (drv_word.rect_height),
    .color_i       (drv_word.color),
    .style_i       (drv_word.style),
    .page_i        (drv_word.page),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (rcv_stall),
    .read_data_o   (read_data_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && drv_valid && !in_stall_o) mirror.note_word(drv_word);
    if (rst_ni && out_valid_o && !rcv_stall) mirror.check_word(read_data_o);
  end

  // A change of hold_seq starts one long stall of the result channel.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rcv_stall <= 1'b1;
      end else begin
        rcv_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [POS_W-1:0] pick_coord(int unsigned last);
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return POS_W'($urandom_range(255));
    if (r == 1) return POS_W'(last - $urandom_range(1));
    return POS_W'($urandom_range(last));
  endfunction

  function automatic logic [POS_W-1:0] pick_span();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return POS_W'($urandom_range(255));
    if (r == 1) return '0;
    return POS_W'($urandom_range(12, 1));
  endfunction

  function automatic draw_word_t random_word();
    draw_word_t w;
    int unsigned r;
    w.cmd = CMD_W'($urandom_range(CMD_UNUSED_LAST));
    w.pos_x = POS_W'($urandom_range(255));
    w.pos_y = POS_W'($urandom_range(255));
    w.rect_width = POS_W'($urandom_range(255));
    w.rect_height = POS_W'($urandom_range(255));
    w.color = 1'($urandom_range(1));
    w.style = 1'($urandom_range(1));
    w.page = PG_W'($urandom_range(7));
    r = $urandom_range(99);
    if (r < 35) begin
      w.cmd = CMD_PIXEL;
      w.pos_x = pick_coord(X_LAST);
      w.pos_y = pick_coord(Y_LAST);
    end else if (r < 55) begin
      w.cmd = CMD_FILL;
      w.pos_x = pick_coord(X_LAST);
      w.pos_y = pick_coord(Y_LAST);
      w.rect_width = pick_span();
      w.rect_height = pick_span();
    end else if (r < 92) begin
      w.cmd = CMD_READ;
      w.pos_x = pick_coord(X_LAST);
    end else if (r < 95) begin
      w.cmd = CMD_BORDER;
    end else if (r < 98) begin
      w.cmd = CMD_CLEAR;
    end else begin
      w.cmd = CMD_W'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
    end
    return w;
  endfunction

  task automatic send_word(draw_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      drv_valid <= 1'b0;
      @(posedge clk_i);
    end
    drv_valid <= 1'b1;
    drv_word <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic send_fields(logic [CMD_W-1:0] cmd, int unsigned x, int unsigned y,
                             int unsigned wd, int unsigned ht, logic color,
                             logic style, int unsigned page);
    draw_word_t w;
    w.cmd = cmd;
    w.pos_x = POS_W'(x);
    w.pos_y = POS_W'(y);
    w.rect_width = POS_W'(wd);
    w.rect_height = POS_W'(ht);
    w.color = color;
    w.style = style;
    w.page = PG_W'(page);
    send_word(w);
  endtask

  task automatic drain_results();
    drv_valid <= 1'b0;
    do @(posedge clk_i); while (mirror.pending_count() != 0);
  endtask

  initial begin
    draw_word_t w;
    int unsigned counted;
    logic held;
    logic paused;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_fields(CMD_PIXEL, 0, 0, 0, 0, 1'b1, 1'b0, 0);
    send_fields(CMD_PIXEL, X_LAST, Y_LAST, 0, 0, 1'b1, 1'b0, 0);
    send_fields(CMD_PIXEL, SCREEN_WIDTH, 5, 0, 0, 1'b1, 1'b0, 0);
    send_fields(CMD_PIXEL, 5, SCREEN_HEIGHT, 0, 0, 1'b1, 1'b0, 0);
    send_fields(CMD_PIXEL, 255, 255, 255, 255, 1'b1, 1'b1, 7);
    send_fields(CMD_READ, 0, 0, 0, 0, 1'b0, 1'b0, 0);
    send_fields(CMD_READ, X_LAST, 0, 0, 0, 1'b0, 1'b0, 7);
    send_fields(CMD_PIXEL, 0, 0, 0, 0, 1'b0, 1'b0, 0);
    send_fields(CMD_READ, 0, 0, 0, 0, 1'b0, 1'b0, 0);
    send_fields(CMD_READ, SCREEN_WIDTH, 0, 0, 0, 1'b0, 1'b0, 0);
    send_fields(CMD_READ, 255, 0, 0, 0, 1'b0, 1'b0, 7);
    send_fields(CMD_FILL, 10, 10, 0, 5, 1'b1, 1'b0, 0);
    send_fields(CMD_FILL, 10, 10, 5, 0, 1'b1, 1'b0, 0);
    send_fields(CMD_FILL, 120, 60, 20, 20, 1'b0, 1'b0, 0);
    send_fields(CMD_FILL, 250, 250, 255, 255, 1'b1, 1'b0, 0);
    send_fields(CMD_READ, X_LAST, 0, 0, 0, 1'b0, 1'b0, 7);
    send_fields(CMD_BORDER, 0, 0, 0, 0, 1'b0, 1'b0, 0);
    send_fields(CMD_READ, 0, 0, 0, 0, 1'b0, 1'b0, 0);
    send_fields(CMD_READ, 1, 0, 0, 0, 1'b0, 1'b0, 0);
    send_fields(CMD_READ, 0, 0, 0, 0, 1'b0, 1'b0, 3);
    send_fields(CMD_BORDER, 0, 0, 0, 0, 1'b0, 1'b1, 0);
    send_fields(CMD_READ, 1, 0, 0, 0, 1'b0, 1'b0, 0);
    send_fields(CMD_UNUSED_FIRST, 3, 3, 3, 3, 1'b1, 1'b1, 3);
    send_fields(CMD_UNUSED_LAST, 255, 255, 255, 255, 1'b1, 1'b1, 7);
    send_fields(CMD_CLEAR, 0, 0, 0, 0, 1'b0, 1'b0, 0);
    send_fields(CMD_READ, X_LAST, 0, 0, 0, 1'b0, 1'b0, 7);
    drain_results();

    held = 1'b0;
    paused = 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct <= 56; end
        default: begin send_idle_pct = 18; recv_stall_pct <= 18; end
      endcase
      counted = 0;
      while (counted < RANDOM_WORDS / 4) begin
        w = random_word();
        send_word(w);
        if (w.cmd <= CMD_READ) counted++;
        if (ph == 0 && counted >= 120 && !held) begin
          held = 1'b1;
          hold_seq <= hold_seq + 1;
        end
        if (ph == 0 && counted >= 300 && !paused) begin
          paused = 1'b1;
          drain_results();
        end
      end
      drain_results();
    end

    send_idle_pct = 0;
    recv_stall_pct <= 0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mirror.fail_count == 0 && mirror.pending_count() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
